[rtl/algebraic_circle_fit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the circle fit block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ALGEBRAIC_CIRCLE_FIT_DEFINES_SVH
`define ALGEBRAIC_CIRCLE_FIT_DEFINES_SVH

// same-cycle implication
`define ACF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/acf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types and constants of the algebraic circle fit.
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int XW         = 16;
    localparam int GUARD_BITS = 4;
    localparam int MW         = 76;              // multiplier operand magnitude
    localparam int PW         = 2 * MW;          // product magnitude
    localparam int SW         = PW + 1;          // signed wide value
    localparam int DVW        = PW + GUARD_BITS; // dividend width
    localparam int FW         = 26;              // fine centre, signed
    localparam int CXW        = 20;
    localparam int RW         = 19;
    localparam int STW        = 3;

    localparam logic [STW-1:0] ST_OK   = 3'd0;
    localparam logic [STW-1:0] ST_FEW  = 3'd1;
    localparam logic [STW-1:0] ST_SING = 3'd2;
    localparam logic [STW-1:0] ST_RNP  = 3'd3;
    localparam logic [STW-1:0] ST_SAT  = 3'd4;

    localparam logic [CXW-1:0] CMAX = 20'h7FFFF;
    localparam logic [CXW-1:0] CMIN = 20'h80000;
    localparam logic [RW-1:0]  RMAX = 19'h7FFFF;

    typedef logic signed [SW-1:0] wide_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic          last;
        logic          keep;
    } item_t;

endpackage

[rtl/acf_point_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_point_if
// Point channel: valid/ready with one edge point per item.
// ----------------------------------------------------------------------------
interface acf_point_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        last_point;

    modport source (output valid, output x_coord, output y_coord, output last_point,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input last_point,
                    output ready);
endinterface

[rtl/acf_fit_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_fit_if
// Result channel: valid/ready with one fitted circle per item.
// ----------------------------------------------------------------------------
interface acf_fit_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] center_x;
    logic signed [19:0] center_y;
    logic [18:0]        radius;
    logic [2:0]         fit_status;

    modport source (output valid, output center_x, output center_y, output radius,
                    output fit_status, input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    input fit_status, output ready);
endinterface

[rtl/acf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_front
// Accepts points, marks those inside the point limit, queues them.
// ----------------------------------------------------------------------------
module acf_front #(
    parameter int MAX_POINTS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    acf_point_if.sink       points,
    output logic            q_valid,
    output acf_pkg::item_t  q_item,
    input  logic            q_pop
);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int DEPTH = 4;
    localparam int AW    = 2;

    acf_pkg::item_t   fifo_mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      cnt_reg, cnt_next;
    logic [CW-1:0]    set_cnt_reg;
    logic             push, keep;
    acf_pkg::item_t   in_item;

    assign points.ready = (cnt_reg != (AW + 1)'(DEPTH));
    assign push         = points.valid && points.ready;
    assign keep         = (set_cnt_reg < CW'(MAX_POINTS));
    assign in_item      = '{x: points.x_coord, y: points.y_coord,
                            last: points.last_point, keep: keep};
    assign q_valid      = (cnt_reg != '0);
    assign q_item       = fifo_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            set_cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                if (points.last_point)
                begin
                    set_cnt_reg <= '0;
                end
                else if (keep)
                begin
                    set_cnt_reg <= set_cnt_reg + 1'b1;
                end
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end
endmodule

[rtl/acf_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_mul
// Shift-add signed multiplier, one operand bit per cycle.
// ----------------------------------------------------------------------------
module acf_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  acf_pkg::wide_t a,
    input  acf_pkg::wide_t b,
    output logic           busy,
    output logic           done,
    output acf_pkg::wide_t prod
);
    localparam int MW   = acf_pkg::MW;
    localparam int PW   = acf_pkg::PW;
    localparam int SW   = acf_pkg::SW;
    localparam int CNTW = $clog2(MW + 1);

    logic [MW-1:0]   a_reg, b_reg;
    logic [PW-1:0]   p_reg, p_next;
    logic            neg_reg, busy_reg, done_reg;
    logic [CNTW-1:0] cnt_reg;
    acf_pkg::wide_t  abs_a, abs_b;
    logic [MW:0]     sum;
    logic [SW-1:0]   mag_ext;

    assign abs_a   = a[SW-1] ? -a : a;
    assign abs_b   = b[SW-1] ? -b : b;
    assign sum     = {1'b0, p_reg[PW-1:MW]} + (b_reg[0] ? {1'b0, a_reg} : '0);
    assign p_next  = {sum, p_reg[MW-1:1]};
    assign mag_ext = {1'b0, p_reg};
    assign prod    = neg_reg ? -mag_ext : mag_ext;
    assign busy    = busy_reg;
    assign done    = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= abs_a[MW-1:0];
            b_reg   <= abs_b[MW-1:0];
            p_reg   <= '0;
            neg_reg <= a[SW-1] ^ b[SW-1];
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(MW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/acf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acf_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [acf_pkg::DVW-1:0]  num,
    input  logic [acf_pkg::PW-1:0]   den,
    output logic                     done,
    output logic [acf_pkg::DVW-1:0]  quo
);
    localparam int DVW  = acf_pkg::DVW;
    localparam int PW   = acf_pkg::PW;
    localparam int CNTW = $clog2(DVW + 1);

    logic [DVW-1:0]  n_reg, q_reg;
    logic [PW-1:0]   d_reg, r_reg;
    logic [PW:0]     rem_sh, rem_sub;
    logic            ge, busy_reg, done_reg;
    logic [CNTW-1:0] cnt_reg;

    assign rem_sh  = {r_reg, n_reg[DVW-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign ge      = (rem_sh >= {1'b0, d_reg});
    assign quo     = q_reg;
    assign done    = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= num;
            d_reg <= den;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg << 1;
            r_reg <= ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
            q_reg <= {q_reg[DVW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DVW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/acf_back.sv]
`timescale 1ns / 1ps
`include "algebraic_circle_fit_defines.svh"
// ----------------------------------------------------------------------------
// acf_back
// Moment accumulation and the fit sequencer, with the output register.
// ----------------------------------------------------------------------------
module acf_back #(
    parameter int MAX_POINTS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  acf_pkg::item_t q_item,
    output logic           q_pop,
    acf_fit_if.source      result
);
    localparam int XW   = acf_pkg::XW;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = XW + CW;
    localparam int SXXW = 2 * XW + CW;
    localparam int SZW  = 2 * XW + 1 + CW;
    localparam int SXZW = 3 * XW + 1 + CW;
    localparam int SW   = acf_pkg::SW;
    localparam int PW   = acf_pkg::PW;
    localparam int DVW  = acf_pkg::DVW;
    localparam int FW   = acf_pkg::FW;
    localparam int CXW  = acf_pkg::CXW;
    localparam int RW   = acf_pkg::RW;
    localparam int G    = acf_pkg::GUARD_BITS;

    localparam logic [4:0] S_IDLE = 5'd0,  S_SQ   = 5'd1,  S_Z    = 5'd2,  S_XZ   = 5'd3;
    localparam logic [4:0] S_ACC  = 5'd4,  S_FIT0 = 5'd5,  S_MA   = 5'd6,  S_MAW  = 5'd7;
    localparam logic [4:0] S_MB   = 5'd8,  S_MBW  = 5'd9,  S_CHKD = 5'd10, S_DX   = 5'd11;
    localparam logic [4:0] S_DXW  = 5'd12, S_DY   = 5'd13, S_DYW  = 5'd14, S_T    = 5'd15;
    localparam logic [4:0] S_TCHK = 5'd16, S_TNW  = 5'd17, S_SQRT = 5'd18, S_RAD  = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    // product-pair steps: r = a*b -/+ c*e
    localparam logic [3:0] K_CXX = 4'd0, K_CYY = 4'd1, K_CXY = 4'd2, K_CXZ = 4'd3;
    localparam logic [3:0] K_CYZ = 4'd4, K_D   = 4'd5, K_NX  = 4'd6, K_NY  = 4'd7;
    localparam logic [3:0] K_U   = 4'd8, K_V   = 4'd9, K_W   = 4'd10;

    logic [4:0]       state_reg, state_next;
    logic [3:0]       step_reg, step_next;

    logic [XW-1:0]    x_reg, y_reg;
    logic             last_reg, keep_reg;
    logic [2*XW-1:0]  xx_reg, yy_reg, xy_reg;
    logic [2*XW:0]    z_reg;
    logic [3*XW:0]    xz_reg, yz_reg;

    logic [CW-1:0]    cnt_reg;
    logic [SXW-1:0]   sum_x_reg, sum_y_reg;
    logic [SXXW-1:0]  sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic [SZW-1:0]   sum_z_reg;
    logic [SXZW-1:0]  sum_xz_reg, sum_yz_reg;

    acf_pkg::wide_t   cxx_reg, cyy_reg, cxy_reg, cxz_reg, cyz_reg, d_reg;
    acf_pkg::wide_t   numx_reg, numy_reg, u_reg, v_reg, w_reg, t_reg, tmp_reg;
    logic signed [FW-1:0] px_reg, py_reg;
    logic             satx_reg;

    logic [63:0]      sq_v_reg, sq_r_reg, sq_bit_reg, sq_trial, rad_w;

    logic [CXW-1:0]   res_cx_reg, res_cy_reg, out_cx_reg, out_cy_reg;
    logic [RW-1:0]    res_rad_reg, out_rad_reg;
    logic [2:0]       res_stat_reg, out_stat_reg;
    logic             out_valid_reg, out_free;

    acf_pkg::wide_t   n_w, sx_w, sy_w, sz_w, sxx_w, syy_w, sxy_w, sxz_w, syz_w, px_w, py_w;
    acf_pkg::wide_t   op_a, op_b, op_c, op_e, mul_a, mul_b, mul_p, pair_res;
    logic             pair_add, mul_start, mul_busy, mul_done;
    logic             div_start, div_done;
    logic [DVW-1:0]   div_num, div_quo;
    logic [PW-1:0]    div_den;
    acf_pkg::wide_t   num_sel, num_mag;

    logic             cneg, big, csat;
    logic [62:0]      q62, raw_c, lim, fm;
    logic [CXW-1:0]   cout;
    logic signed [FW-1:0] fine;

    acf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_p)
    );

    acf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign n_w   = {{(SW-CW){1'b0}}, cnt_reg};
    assign sx_w  = {{(SW-SXW){1'b0}}, sum_x_reg};
    assign sy_w  = {{(SW-SXW){1'b0}}, sum_y_reg};
    assign sz_w  = {{(SW-SZW){1'b0}}, sum_z_reg};
    assign sxx_w = {{(SW-SXXW){1'b0}}, sum_xx_reg};
    assign syy_w = {{(SW-SXXW){1'b0}}, sum_yy_reg};
    assign sxy_w = {{(SW-SXXW){1'b0}}, sum_xy_reg};
    assign sxz_w = {{(SW-SXZW){1'b0}}, sum_xz_reg};
    assign syz_w = {{(SW-SXZW){1'b0}}, sum_yz_reg};
    assign px_w  = {{(SW-FW){px_reg[FW-1]}}, px_reg};
    assign py_w  = {{(SW-FW){py_reg[FW-1]}}, py_reg};

    always_comb
    begin
        op_a = n_w;  op_b = sxx_w; op_c = sx_w; op_e = sx_w; pair_add = 1'b0;
        case (step_reg)
            K_CXX:   begin op_a = n_w;     op_b = sxx_w;   op_c = sx_w;    op_e = sx_w;    end
            K_CYY:   begin op_a = n_w;     op_b = syy_w;   op_c = sy_w;    op_e = sy_w;    end
            K_CXY:   begin op_a = n_w;     op_b = sxy_w;   op_c = sx_w;    op_e = sy_w;    end
            K_CXZ:   begin op_a = n_w;     op_b = sxz_w;   op_c = sx_w;    op_e = sz_w;    end
            K_CYZ:   begin op_a = n_w;     op_b = syz_w;   op_c = sy_w;    op_e = sz_w;    end
            K_D:     begin op_a = cxx_reg; op_b = cyy_reg; op_c = cxy_reg; op_e = cxy_reg; end
            K_NX:    begin op_a = cyy_reg; op_b = cxz_reg; op_c = cxy_reg; op_e = cyz_reg; end
            K_NY:    begin op_a = cxx_reg; op_b = cyz_reg; op_c = cxy_reg; op_e = cxz_reg; end
            K_U:
            begin
                op_a = px_w; op_b = px_w; op_c = py_w; op_e = py_w; pair_add = 1'b1;
            end
            K_V:
            begin
                op_a = px_w; op_b = sx_w; op_c = py_w; op_e = sy_w; pair_add = 1'b1;
            end
            K_W:
            begin
                op_a = n_w; op_b = u_reg; op_c = SW'(2 ** (G + 1)); op_e = v_reg;
            end
            default: ;
        endcase
    end

    assign mul_start = (state_reg == S_MA) || (state_reg == S_MB);
    assign mul_a     = (state_reg == S_MB) ? op_c : op_a;
    assign mul_b     = (state_reg == S_MB) ? op_e : op_b;
    assign pair_res  = pair_add ? tmp_reg + mul_p : tmp_reg - mul_p;

    // centre rounding from the quotient of |num|*2^G / D
    assign num_sel = (state_reg == S_DX) ? numx_reg : numy_reg;
    assign num_mag = num_sel[SW-1] ? -num_sel : num_sel;
    assign cneg    = (state_reg == S_DXW) ? numx_reg[SW-1] : numy_reg[SW-1];
    assign big     = |div_quo[DVW-1:62];
    assign q62     = {1'b0, div_quo[61:0]};
    assign raw_c   = (q62 + 63'd16) >> (G + 1);
    assign lim     = cneg ? 63'(acf_pkg::CMIN) : 63'(acf_pkg::CMAX);
    assign csat    = big || (raw_c > lim);
    assign fm      = (q62 + 63'd1) >> 1;
    assign fine    = cneg ? -fm[FW-1:0] : fm[FW-1:0];
    assign cout    = csat ? (cneg ? acf_pkg::CMIN : acf_pkg::CMAX)
                          : (cneg ? -raw_c[CXW-1:0] : raw_c[CXW-1:0]);

    assign div_start = (state_reg == S_DX) || (state_reg == S_DY) ||
                       ((state_reg == S_TCHK) && !t_reg[SW-1] && (t_reg != '0));
    assign div_num   = (state_reg == S_TCHK) ? {{(DVW-SW){1'b0}}, t_reg}
                                             : {num_mag[PW-1:0], G'(0)};
    assign div_den   = (state_reg == S_TCHK) ? {{(PW-CW){1'b0}}, cnt_reg} : d_reg[PW-1:0];

    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign rad_w    = (sq_r_reg + 64'd8) >> G;

    assign out_free = !out_valid_reg || result.ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    assign result.valid      = out_valid_reg;
    assign result.center_x   = out_cx_reg;
    assign result.center_y   = out_cy_reg;
    assign result.radius     = out_rad_reg;
    assign result.fit_status = out_stat_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_SQ;
            S_SQ:   state_next = S_Z;
            S_Z:    state_next = S_XZ;
            S_XZ:   state_next = S_ACC;
            S_ACC:  state_next = last_reg ? S_FIT0 : S_IDLE;
            S_FIT0:
            begin
                step_next  = K_CXX;
                state_next = (cnt_reg < CW'(3)) ? S_OUT : S_MA;
            end
            S_MA:   state_next = S_MAW;
            S_MAW:  if (mul_done) state_next = S_MB;
            S_MB:   state_next = S_MBW;
            S_MBW:
            begin
                if (mul_done)
                begin
                    if (step_reg == K_NY)
                    begin
                        state_next = S_CHKD;
                    end
                    else if (step_reg == K_W)
                    begin
                        state_next = S_T;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = S_MA;
                    end
                end
            end
            S_CHKD: state_next = (d_reg[SW-1] || d_reg == '0) ? S_OUT : S_DX;
            S_DX:   state_next = S_DXW;
            S_DXW:  if (div_done) state_next = S_DY;
            S_DY:   state_next = S_DYW;
            S_DYW:
            begin
                if (div_done)
                begin
                    step_next  = K_U;
                    state_next = (satx_reg || csat) ? S_OUT : S_MA;
                end
            end
            S_T:    state_next = S_TCHK;
            S_TCHK: state_next = (t_reg[SW-1] || t_reg == '0) ? S_OUT : S_TNW;
            S_TNW:  if (div_done) state_next = S_SQRT;
            S_SQRT: if (sq_bit_reg == '0) state_next = S_RAD;
            S_RAD:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg    <= q_item.x;
                y_reg    <= q_item.y;
                last_reg <= q_item.last;
                keep_reg <= q_item.keep;
            end
            S_SQ:
            begin
                xx_reg <= x_reg * x_reg;
                yy_reg <= y_reg * y_reg;
                xy_reg <= x_reg * y_reg;
            end
            S_Z:  z_reg <= {1'b0, xx_reg} + {1'b0, yy_reg};
            S_XZ:
            begin
                xz_reg <= x_reg * z_reg;
                yz_reg <= y_reg * z_reg;
            end
            S_FIT0:
            begin
                res_cx_reg   <= '0;
                res_cy_reg   <= '0;
                res_rad_reg  <= '0;
                res_stat_reg <= acf_pkg::ST_FEW;
            end
            S_MAW: if (mul_done) tmp_reg <= mul_p;
            S_MBW:
            begin
                if (mul_done)
                begin
                    case (step_reg)
                        K_CXX:   cxx_reg  <= pair_res;
                        K_CYY:   cyy_reg  <= pair_res;
                        K_CXY:   cxy_reg  <= pair_res;
                        K_CXZ:   cxz_reg  <= pair_res;
                        K_CYZ:   cyz_reg  <= pair_res;
                        K_D:     d_reg    <= pair_res;
                        K_NX:    numx_reg <= pair_res;
                        K_NY:    numy_reg <= pair_res;
                        K_U:     u_reg    <= pair_res;
                        K_V:     v_reg    <= pair_res;
                        K_W:     w_reg    <= pair_res;
                        default: ;
                    endcase
                end
            end
            S_CHKD:
            begin
                res_cx_reg   <= '0;
                res_cy_reg   <= '0;
                res_rad_reg  <= '0;
                res_stat_reg <= acf_pkg::ST_SING;
            end
            S_DXW:
            begin
                if (div_done)
                begin
                    res_cx_reg <= cout;
                    px_reg     <= fine;
                    satx_reg   <= csat;
                end
            end
            S_DYW:
            begin
                if (div_done)
                begin
                    res_cy_reg   <= cout;
                    py_reg       <= fine;
                    res_rad_reg  <= acf_pkg::RMAX;
                    res_stat_reg <= acf_pkg::ST_SAT;
                end
            end
            S_T:  t_reg <= w_reg + {{(SW-SZW-2*G){1'b0}}, sum_z_reg, (2 * G)'(0)};
            S_TCHK:
            begin
                res_rad_reg  <= '0;
                res_stat_reg <= acf_pkg::ST_RNP;
            end
            S_TNW:
            begin
                sq_v_reg   <= div_quo[63:0];
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (sq_bit_reg != '0)
                begin
                    if (sq_v_reg >= sq_trial)
                    begin
                        sq_v_reg <= sq_v_reg - sq_trial;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
            end
            S_RAD:
            begin
                if (rad_w > 64'(acf_pkg::RMAX))
                begin
                    res_rad_reg  <= acf_pkg::RMAX;
                    res_stat_reg <= acf_pkg::ST_SAT;
                end
                else
                begin
                    res_rad_reg  <= rad_w[RW-1:0];
                    res_stat_reg <= acf_pkg::ST_OK;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_cx_reg   <= res_cx_reg;
                    out_cy_reg   <= res_cy_reg;
                    out_rad_reg  <= res_rad_reg;
                    out_stat_reg <= res_stat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= K_CXX;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_yy_reg    <= '0;
            sum_xy_reg    <= '0;
            sum_z_reg     <= '0;
            sum_xz_reg    <= '0;
            sum_yz_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_Z) && keep_reg)
            begin
                cnt_reg    <= cnt_reg + 1'b1;
                sum_x_reg  <= sum_x_reg + SXW'(x_reg);
                sum_y_reg  <= sum_y_reg + SXW'(y_reg);
                sum_xx_reg <= sum_xx_reg + SXXW'(xx_reg);
                sum_yy_reg <= sum_yy_reg + SXXW'(yy_reg);
                sum_xy_reg <= sum_xy_reg + SXXW'(xy_reg);
            end
            if ((state_reg == S_ACC) && keep_reg)
            begin
                sum_z_reg  <= sum_z_reg + SZW'(z_reg);
                sum_xz_reg <= sum_xz_reg + SXZW'(xz_reg);
                sum_yz_reg <= sum_yz_reg + SXZW'(yz_reg);
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                cnt_reg       <= '0;
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
                sum_xx_reg    <= '0;
                sum_yy_reg    <= '0;
                sum_xy_reg    <= '0;
                sum_z_reg     <= '0;
                sum_xz_reg    <= '0;
                sum_yz_reg    <= '0;
            end
        end
    end

    `ACF_ASSERT_NOW(a_pop_idle, q_pop, state_reg == S_IDLE, "queue pop outside idle")
    `ACF_ASSERT_NOW(a_mul_free, mul_start, !mul_busy, "multiplier restarted while busy")
    `ACF_ASSERT_NOW(a_few_zero, out_valid_reg && (out_stat_reg == acf_pkg::ST_FEW), (out_cx_reg == '0) && (out_cy_reg == '0) && (out_rad_reg == '0), "short set gave nonzero fit")
    `ACF_ASSERT_NEXT(a_out_hold, out_valid_reg && !result.ready, out_valid_reg && $stable(out_stat_reg), "result dropped while stalled")
endmodule

[rtl/algebraic_circle_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// algebraic_circle_fit
// Least-squares circle fit over a stream of edge points.
// ----------------------------------------------------------------------------
// Points enter on the points channel (Q12.4 x/y, last_point closes a set).
// One fitted circle leaves on the result channel per set, after the last
// point: centre in signed Q15.4, radius in Q15.4, and a status code.
// A point passes the states S_SQ, S_Z, S_XZ and S_ACC of the accumulator;
// the front queue holds four points, so the points channel stalls only
// when the queue is full. The fit after a last point runs on a bit-serial
// multiplier (22 products) and a bit-serial divider (three divisions),
// plus a square root; queued points of the next set wait for the fit to
// end.
// Reset clears the moment sums, the queue and the output valid flag.
// A result waits in the output register while the receiver stalls; the
// block keeps accumulating the next set and holds the next result until
// the register frees up.
// ----------------------------------------------------------------------------
module algebraic_circle_fit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    acf_point_if.sink   points,
    acf_fit_if.source   result
);
    logic           q_valid, q_pop;
    acf_pkg::item_t q_item;

    acf_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    acf_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .result  (result)
    );
endmodule

[tb/sv/tb_algebraic_circle_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_algebraic_circle_fit
// Self-checking bench for the algebraic circle fit. Point sets (circles,
// noise, collinear and clustered sets, one set past the point cap) are
// streamed with random gaps and receiver stalls. An exact wide-integer
// predictor computes each expected circle, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_algebraic_circle_fit;

    localparam int LIMIT      = 30000000;
    localparam int CAP        = 1024;
    localparam int HOLD_CYC   = 6000;

    typedef logic signed [255:0] bigw_t;

    typedef struct {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic [18:0]        r;
        logic [2:0]         st;
    } circle_t;

    class fit_scoreboard;
        int unsigned npts;
        logic [63:0] s_x, s_y, s_xx, s_yy, s_xy, s_z, s_xz, s_yz;
        circle_t     circles_q[$];
        int          errors;
        int          fits;
        int          status_seen[5];

        function void clear_sums();
            npts = 0;
            s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0; s_z = 0; s_xz = 0; s_yz = 0;
        endfunction

        function bigw_t widen(logic [63:0] v);
            return $signed({192'd0, v});
        endfunction

        function int pending();
            return circles_q.size();
        endfunction

        function logic centre(bigw_t num, bigw_t den, output logic signed [63:0] fine,
                              output logic [19:0] outv);
            logic [255:0] mag, q, dmag;
            logic [63:0]  raw, fm;
            logic         neg, big;
            neg  = num < 0;
            mag  = neg ? -num : num;
            dmag = den;
            q    = (mag << acf_pkg::GUARD_BITS) / dmag;
            big  = q >= (256'd1 << 62);
            raw  = big ? 64'd0 : (q[63:0] + 64'd16) >> 5;
            if (big || raw > (neg ? 64'd524288 : 64'd524287))
            begin
                outv = neg ? acf_pkg::CMIN : acf_pkg::CMAX;
                fine = 0;
                return 1'b1;
            end
            fm   = (q[63:0] + 64'd1) >> 1;
            outv = neg ? -raw[19:0] : raw[19:0];
            fine = neg ? -$signed(fm) : $signed(fm);
            return 1'b0;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [127:0] r, c;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = r | (128'd1 << b);
                if (c * c <= {64'd0, v})
                    r = c;
            end
            return r[63:0];
        endfunction

        function circle_t fit_circle();
            circle_t             c;
            bigw_t               n, sx, sy, sz, cxx, cyy, cxy, cxz, cyz, det, numx, numy;
            logic signed [63:0]  px, py;
            logic signed [127:0] t, pxw, pyw, sxw, syw, szw, nw;
            logic [19:0]         ox, oy;
            logic                satx, saty;
            logic [63:0]         rad;
            c.cx = 0; c.cy = 0; c.r = 0; c.st = acf_pkg::ST_FEW;
            if (npts < 3)
                return c;
            n   = widen(64'(npts));
            sx  = widen(s_x);
            sy  = widen(s_y);
            sz  = widen(s_z);
            cxx = n * widen(s_xx) - sx * sx;
            cyy = n * widen(s_yy) - sy * sy;
            cxy = n * widen(s_xy) - sx * sy;
            cxz = n * widen(s_xz) - sx * sz;
            cyz = n * widen(s_yz) - sy * sz;
            det = cxx * cyy - cxy * cxy;
            if (det <= 0)
            begin
                c.st = acf_pkg::ST_SING;
                return c;
            end
            numx = cyy * cxz - cxy * cyz;
            numy = cxx * cyz - cxy * cxz;
            satx = centre(numx, det, px, ox);
            saty = centre(numy, det, py, oy);
            c.cx = ox;
            c.cy = oy;
            if (satx || saty)
            begin
                c.r  = acf_pkg::RMAX;
                c.st = acf_pkg::ST_SAT;
                return c;
            end
            pxw = px; pyw = py;
            sxw = $signed({64'd0, s_x});
            syw = $signed({64'd0, s_y});
            szw = $signed({64'd0, s_z});
            nw  = npts;
            t = szw * 256 - 32 * (pxw * sxw + pyw * syw) + nw * (pxw * pxw + pyw * pyw);
            if (t <= 0)
            begin
                c.st = acf_pkg::ST_RNP;
                return c;
            end
            rad = (floor_sqrt(64'(t / nw)) + 64'd8) >> acf_pkg::GUARD_BITS;
            if (rad > 64'(acf_pkg::RMAX))
            begin
                c.r  = acf_pkg::RMAX;
                c.st = acf_pkg::ST_SAT;
                return c;
            end
            c.r  = rad[18:0];
            c.st = acf_pkg::ST_OK;
            return c;
        endfunction

        function void note_point(logic [15:0] x, logic [15:0] y, logic last);
            logic [63:0] xx, yy, z;
            xx = x;
            yy = y;
            if (npts < CAP)
            begin
                z = xx * xx + yy * yy;
                npts++;
                s_x  += xx;
                s_y  += yy;
                s_xx += xx * xx;
                s_yy += yy * yy;
                s_xy += xx * yy;
                s_z  += z;
                s_xz += xx * z;
                s_yz += yy * z;
            end
            if (last)
            begin
                circles_q.insert(circles_q.size(), fit_circle());
                clear_sums();
            end
        endfunction

        task report_mismatch(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(circle_t got);
            circle_t want;
            if (circles_q.size() == 0)
            begin
                report_mismatch("result with nothing expected");
                return;
            end
            want = circles_q.pop_front();
            fits++;
            if (want.st <= acf_pkg::ST_SAT)
                status_seen[want.st]++;
            if (got.cx !== want.cx)
                report_mismatch($sformatf("center_x got %0d want %0d", got.cx, want.cx));
            if (got.cy !== want.cy)
                report_mismatch($sformatf("center_y got %0d want %0d", got.cy, want.cy));
            if (got.r !== want.r)
                report_mismatch($sformatf("radius got %0d want %0d", got.r, want.r));
            if (got.st !== want.st)
                report_mismatch($sformatf("fit_status got %0d want %0d", got.st, want.st));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   n_points;
    int   n_sets;
    logic calm;
    logic hold_req;
    int   holds_done;

    acf_point_if pts ();
    acf_fit_if   res ();

    fit_scoreboard sb = new();

    algebraic_circle_fit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pts),
        .result (res)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
                holds_done++;
            end
            else
                res.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        circle_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.cx = res.center_x;
            got.cy = res.center_y;
            got.r  = res.radius;
            got.st = res.fit_status;
            sb.check_result(got);
        end
    end

    task automatic offer_point(input logic [15:0] x, input logic [15:0] y, input logic last);
        if (!calm)
            while ($urandom_range(99) < 20)
            begin
                @(negedge clk);
                pts.valid <= 1'b0;
            end
        @(negedge clk);
        pts.valid      <= 1'b1;
        pts.x_coord    <= x;
        pts.y_coord    <= y;
        pts.last_point <= last;
        do @(posedge clk); while (!pts.ready);
        sb.note_point(x, y, last);
        n_points++;
        if (last)
            n_sets++;
    endtask

    task automatic drain();
        @(negedge clk);
        pts.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] clamp16(real v);
        if (v < 0.0)
            return 16'd0;
        if (v > 65535.0)
            return 16'hFFFF;
        return 16'($rtoi(v + 0.5));
    endfunction

    // kind: 0..5 circle, 6 noise, 7 collinear, 8 cluster
    task automatic send_set(input int kind, input int size);
        int   cx, cy, rr, dx, dy, k;
        real  a;
        logic [15:0] x, y;
        cx = $urandom_range(65535);
        cy = $urandom_range(65535);
        rr = ($urandom_range(3) == 0) ? $urandom_range(4, 400) : $urandom_range(4, 30000);
        dx = $urandom_range(200);
        dy = $urandom_range(200);
        if (kind == 7)
        begin
            cx = $urandom_range(60000);
            cy = $urandom_range(60000);
        end
        for (k = 0; k < size; k++)
        begin
            a = $urandom_range(3599) * 3.14159265 / 1800.0;
            case (kind)
                6: begin x = 16'($urandom); y = 16'($urandom); end
                7: begin x = 16'(cx + k * dx); y = 16'(cy + k * dy); end
                8: begin x = clamp16(cx + $urandom_range(3)); y = clamp16(cy + $urandom_range(3)); end
                default:
                begin
                    x = clamp16(cx + rr * $cos(a) + $urandom_range(4) - 2.0);
                    y = clamp16(cy + rr * $sin(a) + $urandom_range(4) - 2.0);
                end
            endcase
            offer_point(x, y, k == size - 1);
        end
    endtask

    initial
    begin
        int set_idx, kind, size;
        rst_n          = 1'b0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        pts.valid      = 1'b0;
        pts.x_coord    = '0;
        pts.y_coord    = '0;
        pts.last_point = 1'b0;
        sb.clear_sums();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // single point, two points, collinear, coincident
        offer_point(16'd0, 16'd0, 1'b1);
        offer_point(16'hFFFF, 16'hFFFF, 1'b0);
        offer_point(16'd0, 16'hFFFF, 1'b1);
        offer_point(16'd0, 16'd0, 1'b0);
        offer_point(16'd0, 16'd100, 1'b0);
        offer_point(16'd0, 16'hFFFF, 1'b1);
        offer_point(16'hFFFF, 16'hFFFF, 1'b0);
        offer_point(16'hFFFF, 16'hFFFF, 1'b0);
        offer_point(16'hFFFF, 16'hFFFF, 1'b1);
        // corner triangle, nearly collinear (centre out of range), unit triangle, square
        offer_point(16'd0, 16'd0, 1'b0);
        offer_point(16'hFFFF, 16'd0, 1'b0);
        offer_point(16'd0, 16'hFFFF, 1'b1);
        offer_point(16'd0, 16'd0, 1'b0);
        offer_point(16'hFFFF, 16'd1, 1'b0);
        offer_point(16'h8000, 16'd0, 1'b1);
        offer_point(16'd0, 16'd0, 1'b0);
        offer_point(16'd1, 16'd0, 1'b0);
        offer_point(16'd0, 16'd1, 1'b1);
        offer_point(16'h5555, 16'hAAAA, 1'b0);
        offer_point(16'hAAAA, 16'h5555, 1'b0);
        offer_point(16'h5555, 16'h5555, 1'b0);
        offer_point(16'hAAAA, 16'hAAAA, 1'b1);
        drain();

        set_idx = 0;
        while (n_points < 1500)
        begin
            set_idx++;
            if (set_idx == 10)
                hold_req = 1'b1;
            if (set_idx == 20)
                drain();
            calm = (set_idx >= 30 && set_idx < 50);
            if (set_idx == 55)
                send_set(0, CAP + 6);
            else
            begin
                kind = $urandom_range(8);
                size = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
                send_set(kind, size);
            end
        end
        @(negedge clk);
        pts.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("tb: %0d points in %0d sets, %0d fits checked, %0d long stalls",
                 n_points, n_sets, sb.fits, holds_done);
        $display("tb: status ok %0d few %0d singular %0d nonpositive %0d saturated %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/acf_pkg.sv
rtl/acf_point_if.sv
rtl/acf_fit_if.sv
rtl/acf_front.sv
rtl/acf_mul.sv
rtl/acf_div.sv
rtl/acf_back.sv
rtl/algebraic_circle_fit.sv
tb/sv/tb_algebraic_circle_fit.sv
